// ----- src/sdi_pkg.sv -----
package sdi_pkg;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       select_active;
        logic       slow_clock;
        logic       done_res;
        logic [2:0] card_type;
    } out_item_t;

    typedef enum logic [2:0] {
        CFG_DUMMY   = 3'd0,
        CFG_POLL    = 3'd1,
        CFG_RETRY   = 3'd2,
        CFG_DELAY   = 3'd3,
        CFG_BUSY    = 3'd4,
        CFG_BLKLEN  = 3'd5
    } cfg_idx_t;

    localparam int CFG_DATA_W = 13;
    localparam int QUEUE_DEPTH = 2;

    // Classified beat handed from the front to the back
    typedef struct packed {
        logic       is_start;
        logic       is_byte;
        logic       is_tick;
        logic [7:0] rx;
    } op_t;

endpackage

// ----- src/sd_spi_card_init_sequencer_unit.sv -----
// SD card SPI-mode initialization sequencer.
// Input channel (in_valid/in_stall/in_data): one beat per event: start,
// byte received from the card on the last exchange, or one timer tick.
// Output channel (out_valid/out_stall/out_data): exactly one beat per input
// beat, giving the next exchange request (byte, chip select, slow clock) and,
// once finished, done with the card type (0 means failure).
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// write only while idle.
// A result beat passes through the queue write and then the sequencer step into
// the output register once its input beat is accepted.
// The unit takes one beat per cycle while the receiver does not stall.
// A two-entry queue separates the input decode from the sequencer.
// Reset clears the sequencer to idle, no card known, and loads the register
// defaults. When the receiver stalls, the output beat holds, the sequencer
// stops and the queue fills, after which in_stall rises.
module sd_spi_card_init_sequencer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [sdi_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  sdi_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output sdi_pkg::out_item_t            out_data
);
    import sdi_pkg::*;

    logic q_valid, q_stall;
    op_t  q_data;

    sdi_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data)
    );

    sdi_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );
endmodule

// ----- src/sdi_front.sv -----
module sdi_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sdi_pkg::in_item_t in_data,
    output logic              q_valid,
    input  logic              q_stall,
    output sdi_pkg::op_t      q_data
);
    import sdi_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    op_t           mem_reg [QUEUE_DEPTH];
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] rd_reg, wr_reg;
    op_t           op;
    logic          push, pop;

    // Decode the beat kind
    always_comb
    begin
        op.is_start = (in_data.kind == KIND_START);
        op.is_byte  = (in_data.kind == KIND_BYTE);
        op.is_tick  = (in_data.kind == KIND_TICK);
        op.rx       = in_data.rx_byte;
    end

    assign in_stall = (cnt_reg == CW'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && !q_stall;
    assign q_data   = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= op;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= '0;
            wr_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end
endmodule

// ----- src/sdi_back.sv -----
module sdi_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [sdi_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          q_valid,
    output logic                          q_stall,
    input  sdi_pkg::op_t                  q_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output sdi_pkg::out_item_t            out_data
);
    import sdi_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_DONE, PH_PWR_DUMMY, PH_PWR_CMD0, PH_PWR_UNSEL, PH_CMD0,
        PH_CMD8, PH_CMD8_ECHO, PH_V2_CMD55, PH_V2_ACMD41, PH_V2_DELAY,
        PH_CMD58, PH_CMD58_OCR, PH_V1_PROBE55, PH_V1_PROBE41, PH_V1_CMD55,
        PH_V1_ACMD41, PH_V1_CMD1, PH_V1_DELAY, PH_CMD16, PH_FINAL_UNSEL
    } phase_t;

    localparam logic [2:0] SUB_BUSY = 3'd0;
    localparam logic [2:0] SUB_POLL = 3'd7;

    logic [7:0]  dummy_reg, poll_reg, retry_lim_reg;
    logic [9:0]  delay_reg;
    logic [11:0] busy_reg;
    logic [12:0] blklen_reg;

    phase_t      ph_reg, ph_next;
    logic [2:0]  fi_reg, fi_next;
    logic [7:0]  bc_reg, bc_next, rc_reg, rc_next;
    logic [11:0] tc_reg, tc_next;
    logic [31:0] rs_reg, rs_next;
    logic [2:0]  ft_reg, ft_next;
    logic        pw_reg, pw_next;
    logic        ov_reg;
    out_item_t   od_reg, od_next;
    logic        take;
    logic        is_cmd;
    logic [7:0]  r1;
    logic        cmd_done;
    logic [7:0]  code;
    logic [31:0] arg;

    assign q_stall   = ov_reg && out_stall;
    assign take      = q_valid && !q_stall;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    function automatic logic cmd_phase(phase_t p);
        cmd_phase = (p inside {PH_PWR_CMD0, PH_CMD0, PH_CMD8, PH_V2_CMD55, PH_V2_ACMD41,
                               PH_CMD58, PH_V1_PROBE55, PH_V1_PROBE41, PH_V1_CMD55,
                               PH_V1_ACMD41, PH_V1_CMD1, PH_CMD16});
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dummy_reg     <= 8'd10;
            poll_reg      <= 8'd100;
            retry_lim_reg <= 8'd100;
            delay_reg     <= 10'd10;
            busy_reg      <= 12'd500;
            blklen_reg    <= 13'd512;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DUMMY:  dummy_reg     <= cfg_data[7:0];
                CFG_POLL:   poll_reg      <= cfg_data[7:0];
                CFG_RETRY:  retry_lim_reg <= cfg_data[7:0];
                CFG_DELAY:  delay_reg     <= cfg_data[9:0];
                CFG_BUSY:   busy_reg      <= cfg_data[11:0];
                CFG_BLKLEN: blklen_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        logic [7:0] tmp8;
        logic       fire;
        logic [7:0] cr;
        phase_t     np;
        ph_next = ph_reg; fi_next = fi_reg; bc_next = bc_reg; rc_next = rc_reg;
        tc_next = tc_reg; rs_next = rs_reg; ft_next = ft_reg; pw_next = pw_reg;
        is_cmd  = cmd_phase(ph_reg);
        r1 = 8'hFF; cmd_done = 1'b0; tmp8 = '0; fire = 1'b0; cr = '0; np = ph_reg;
        if (take && q_data.is_start)
        begin
            if (ph_reg == PH_IDLE || ph_reg == PH_DONE)
            begin
                if (ft_reg != '0 && pw_reg)
                begin
                    ph_next = PH_DONE;
                end
                else
                begin
                    pw_next = 1'b0; ft_next = '0;
                    rc_next = (retry_lim_reg != '0) ? retry_lim_reg : 8'd1;
                    bc_next = dummy_reg;
                    if (dummy_reg == '0)
                    begin
                        ph_next = PH_PWR_CMD0; fi_next = SUB_BUSY; tc_next = '0;
                    end
                    else
                    begin
                        ph_next = PH_PWR_DUMMY;
                    end
                end
            end
        end
        else if (take && q_data.is_byte)
        begin
            if (is_cmd)
            begin
                if (fi_reg == SUB_BUSY)
                begin
                    if (q_data.rx == 8'hFF)
                    begin
                        fi_next = 3'd1;
                    end
                    else if (tc_reg > busy_reg || tc_reg == 12'hFFF)
                    begin
                        cmd_done = 1'b1; r1 = 8'hFF;
                    end
                end
                else if (fi_reg < 3'd6)
                begin
                    fi_next = fi_reg + 3'd1;
                end
                else if (fi_reg == 3'd6)
                begin
                    fi_next = SUB_POLL;
                    bc_next = (poll_reg != '0) ? poll_reg : 8'd1;
                end
                else
                begin
                    tmp8 = bc_reg - 8'd1;
                    bc_next = tmp8;
                    if (!q_data.rx[7] || tmp8 == '0)
                    begin
                        cmd_done = 1'b1; r1 = q_data.rx;
                    end
                end
            end
            else
            begin
                case (ph_reg)
                    PH_PWR_DUMMY:
                    begin
                        tmp8 = bc_reg - 8'd1;
                        bc_next = tmp8;
                        if (tmp8 == '0)
                        begin
                            ph_next = PH_PWR_CMD0; fi_next = SUB_BUSY; tc_next = '0;
                        end
                    end
                    PH_PWR_UNSEL:
                    begin
                        if (pw_reg)
                        begin
                            ph_next = PH_CMD0; fi_next = SUB_BUSY; tc_next = '0;
                        end
                        else
                        begin
                            ft_next = '0; ph_next = PH_DONE;
                        end
                    end
                    PH_CMD8_ECHO, PH_CMD58_OCR:
                    begin
                        rs_next = {rs_reg[23:0], q_data.rx};
                        fi_next = fi_reg + 3'd1;
                        if (fi_reg == 3'd3)
                        begin
                            fi_next = '0;
                            if (ph_reg == PH_CMD58_OCR)
                            begin
                                ft_next = rs_next[30] ? 3'd4 : 3'd3;
                                ph_next = PH_FINAL_UNSEL;
                            end
                            else if (rs_next == 32'h0000_01AA)
                            begin
                                ph_next = PH_V2_CMD55; fi_next = SUB_BUSY; tc_next = '0;
                            end
                            else
                            begin
                                ft_next = '0; ph_next = PH_FINAL_UNSEL;
                            end
                        end
                    end
                    PH_FINAL_UNSEL:
                    begin
                        if (ft_reg == '0)
                        begin
                            pw_next = 1'b0;
                        end
                        ph_next = PH_DONE;
                    end
                    default: ;
                endcase
            end
        end
        else if (take && q_data.is_tick)
        begin
            if (is_cmd && fi_reg == SUB_BUSY)
            begin
                if (tc_reg != 12'hFFF)
                begin
                    tc_next = tc_reg + 12'd1;
                end
            end
            else if (ph_reg == PH_V2_DELAY || ph_reg == PH_V1_DELAY)
            begin
                tc_next = (tc_reg != 12'hFFF) ? tc_reg + 12'd1 : tc_reg;
                if (tc_next >= {2'b00, delay_reg})
                begin
                    tmp8 = rc_reg - 8'd1;
                    rc_next = tmp8;
                    if (tmp8 == '0)
                    begin
                        ft_next = '0; ph_next = PH_FINAL_UNSEL;
                    end
                    else
                    begin
                        ph_next = (ph_reg == PH_V2_DELAY) ? PH_V2_CMD55 :
                                  ((ft_reg == 3'd2) ? PH_V1_CMD55 : PH_V1_CMD1);
                        fi_next = SUB_BUSY; tc_next = '0;
                    end
                end
            end
        end

        // Command completion dispatch
        if (cmd_done)
        begin
            cr = r1;
            fire = 1'b0;
            np = ph_reg;
            case (ph_reg)
                PH_PWR_CMD0:
                begin
                    if (cr == 8'h01) pw_next = 1'b1;
                    ph_next = PH_PWR_UNSEL;
                end
                PH_CMD0:
                begin
                    if (cr == 8'h01) begin np = PH_CMD8; fire = 1'b1; end
                    else begin ft_next = '0; ph_next = PH_FINAL_UNSEL; end
                end
                PH_CMD8:
                begin
                    if (cr == 8'h01)
                    begin
                        ph_next = PH_CMD8_ECHO; fi_next = '0; rs_next = '0;
                    end
                    else begin np = PH_V1_PROBE55; fire = 1'b1; end
                end
                PH_V2_CMD55:
                begin
                    if (cr <= 8'd1) begin np = PH_V2_ACMD41; fire = 1'b1; end
                    else begin ph_next = PH_V2_DELAY; tc_next = '0; end
                end
                PH_V2_ACMD41:
                begin
                    if (cr == 8'd0) begin np = PH_CMD58; fire = 1'b1; end
                    else begin ph_next = PH_V2_DELAY; tc_next = '0; end
                end
                PH_CMD58:
                begin
                    if (cr == 8'd0)
                    begin
                        ph_next = PH_CMD58_OCR; fi_next = '0; rs_next = '0;
                    end
                    else begin ft_next = '0; ph_next = PH_FINAL_UNSEL; end
                end
                PH_V1_PROBE55:
                begin
                    if (cr <= 8'd1) np = PH_V1_PROBE41;
                    else begin ft_next = 3'd1; np = PH_V1_CMD1; end
                    fire = 1'b1;
                end
                PH_V1_PROBE41:
                begin
                    ft_next = (cr <= 8'd1) ? 3'd2 : 3'd1;
                    np = (cr <= 8'd1) ? PH_V1_CMD55 : PH_V1_CMD1;
                    fire = 1'b1;
                end
                PH_V1_CMD55:
                begin
                    if (cr <= 8'd1) begin np = PH_V1_ACMD41; fire = 1'b1; end
                    else begin ph_next = PH_V1_DELAY; tc_next = '0; end
                end
                PH_V1_ACMD41, PH_V1_CMD1:
                begin
                    if (cr == 8'd0) begin np = PH_CMD16; fire = 1'b1; end
                    else begin ph_next = PH_V1_DELAY; tc_next = '0; end
                end
                default:
                begin
                    if (cr != 8'd0) ft_next = '0;
                    ph_next = PH_FINAL_UNSEL;
                end
            endcase
            if (fire)
            begin
                ph_next = np; fi_next = SUB_BUSY; tc_next = '0;
            end
        end
    end

    // Frame byte for the next phase
    always_comb
    begin
        case (ph_next)
            PH_CMD8:                                     code = 8'h48;
            PH_V2_CMD55, PH_V1_PROBE55, PH_V1_CMD55:     code = 8'h77;
            PH_V2_ACMD41, PH_V1_PROBE41, PH_V1_ACMD41:   code = 8'h69;
            PH_V1_CMD1:                                  code = 8'h41;
            PH_CMD58:                                    code = 8'h7A;
            PH_CMD16:                                    code = 8'h50;
            default:                                     code = 8'h40;
        endcase
        case (ph_next)
            PH_CMD8:      arg = 32'h0000_01AA;
            PH_V2_ACMD41: arg = 32'h4000_0000;
            PH_CMD16:     arg = {19'd0, blklen_reg};
            default:      arg = '0;
        endcase
    end

    // Result beat
    always_comb
    begin
        od_next = '{tx_valid: 1'b0, tx_byte: 8'hFF, select_active: 1'b0,
                    slow_clock: 1'b0, done_res: 1'b0, card_type: 3'd0};
        if (ph_next == PH_DONE)
        begin
            od_next.done_res  = 1'b1;
            od_next.card_type = ft_next;
        end
        else if (ph_next != PH_IDLE)
        begin
            od_next.slow_clock = 1'b1;
            if (ph_next inside {PH_PWR_DUMMY, PH_PWR_UNSEL, PH_FINAL_UNSEL})
            begin
                od_next.tx_valid = 1'b1;
            end
            else if (ph_next inside {PH_V2_DELAY, PH_V1_DELAY})
            begin
                od_next.select_active = 1'b1;
            end
            else
            begin
                od_next.tx_valid = 1'b1;
                od_next.select_active = 1'b1;
                if (cmd_phase(ph_next))
                begin
                    case (fi_next)
                        3'd1: od_next.tx_byte = code;
                        3'd2: od_next.tx_byte = arg[31:24];
                        3'd3: od_next.tx_byte = arg[23:16];
                        3'd4: od_next.tx_byte = arg[15:8];
                        3'd5: od_next.tx_byte = arg[7:0];
                        3'd6: od_next.tx_byte = (code == 8'h40) ? 8'h95 :
                                                ((code == 8'h48) ? 8'h87 : 8'h01);
                        default: od_next.tx_byte = 8'hFF;
                    endcase
                end
            end
        end
    end

    // State and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_IDLE; fi_reg <= '0; bc_reg <= '0; rc_reg <= '0;
            tc_reg <= '0; rs_reg <= '0; ft_reg <= '0; pw_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                ph_reg <= ph_next; fi_reg <= fi_next; bc_reg <= bc_next;
                rc_reg <= rc_next; tc_reg <= tc_next; rs_reg <= rs_next;
                ft_reg <= ft_next; pw_reg <= pw_next;
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            od_reg <= od_next;
        end
    end
endmodule
